### hdl/cph_pkg.sv
// ----------------------------------------------------------------------------
// cph_pkg
// Shared types and constants for the hysteresis comparator peripheral.
// ----------------------------------------------------------------------------
package cph_pkg;

    localparam int LEVEL_BITS_DEF = 16;
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STATUS_ADDR = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HYST_BAND   = 4'd1;

    // Actions
    localparam logic [2:0] ACT_READ    = 3'd0;
    localparam logic [2:0] ACT_WRITE   = 3'd1;
    localparam logic [2:0] ACT_SET_POS = 3'd2;
    localparam logic [2:0] ACT_SET_NEG = 3'd3;
    localparam logic [2:0] ACT_TICK    = 3'd4;
    localparam logic [2:0] ACT_IRQ_ACK = 3'd5;

    // Status register bit positions
    localparam int BIT_DISABLE = 7;
    localparam int BIT_OUTPUT  = 5;
    localparam int BIT_FLAG    = 4;
    localparam int BIT_IE      = 3;

    // Edge modes
    localparam logic [1:0] MODE_TOGGLE  = 2'd0;
    localparam logic [1:0] MODE_NONE    = 2'd1;
    localparam logic [1:0] MODE_FALLING = 2'd2;
    localparam logic [1:0] MODE_RISING  = 2'd3;

    // Settling delays in ticks
    localparam logic [3:0] DLY_FAST   = 4'd1;
    localparam logic [3:0] DLY_MEDIUM = 4'd2;
    localparam logic [3:0] DLY_SLOW   = 4'd4;
    localparam logic [3:0] DLY_CRAWL  = 4'd8;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
        logic [15:0] level;
    } t_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic       comparator_out;
        logic       irq_request;
        logic       ack_taken;
    } t_out;

    // Outcome of a comparison re-evaluation
    typedef struct packed {
        logic       load;       // raw result toggled while enabled: take the fields below
        logic       raw;
        logic       pending;
        logic [3:0] countdown;
    } t_eval;

endpackage

### hdl/cph_eval.sv
// ----------------------------------------------------------------------------
// cph_eval
// Hysteresis comparison and overdrive-dependent settling delay selection.
// ----------------------------------------------------------------------------
module cph_eval #(
    parameter int LEVEL_BITS = cph_pkg::LEVEL_BITS_DEF
) (
    input  logic [LEVEL_BITS-1:0] i_pos,
    input  logic [LEVEL_BITS-1:0] i_neg,
    input  logic [15:0]           i_band,
    input  logic                  i_raw,
    input  logic                  i_settled,
    input  logic                  i_off,
    output cph_pkg::t_eval        o_eval
);
    import cph_pkg::*;

    localparam int WB = (LEVEL_BITS > 16) ? LEVEL_BITS : 16;
    localparam int WX = LEVEL_BITS + 8;
    // Full scale, 1.0 = 2^LEVEL_BITS
    localparam logic [WX-1:0] FULL = WX'(1) << LEVEL_BITS;

    logic [LEVEL_BITS:0]   w_diff;
    logic                  w_pos_ge;
    logic [LEVEL_BITS-1:0] w_od;
    logic                  w_over_band;
    logic                  w_next;
    logic [WX-1:0]         w_od_x;
    logic [WX-1:0]         w_od10;
    logic [WX-1:0]         w_od50;
    logic [WX-1:0]         w_od100;
    logic [3:0]            w_delay;

    assign w_diff   = {1'b0, i_pos} - {1'b0, i_neg};
    assign w_pos_ge = !w_diff[LEVEL_BITS];
    assign w_od     = w_pos_ge ? w_diff[LEVEL_BITS-1:0] : (i_neg - i_pos);

    assign w_over_band = WB'(w_od) > WB'(i_band);

    // Overdrive scaled by 10, 50 and 100 against full scale (0.1, 0.02, 0.01)
    assign w_od_x  = WX'(w_od);
    assign w_od10  = (w_od_x << 3) + (w_od_x << 1);
    assign w_od50  = (w_od_x << 5) + (w_od_x << 4) + (w_od_x << 1);
    assign w_od100 = w_od50 << 1;

    always_comb begin
        if (w_od10 >= FULL) begin
            w_delay = DLY_FAST;
        end else if (w_od50 > FULL) begin
            w_delay = DLY_MEDIUM;
        end else if (w_od100 > FULL) begin
            w_delay = DLY_SLOW;
        end else begin
            w_delay = DLY_CRAWL;
        end
    end

    always_comb begin
        w_next = i_raw;
        if (i_raw) begin
            if (!w_pos_ge && w_over_band) begin
                w_next = 1'b0;
            end
        end else begin
            if (w_pos_ge && w_over_band) begin
                w_next = 1'b1;
            end
        end
    end

    always_comb begin
        o_eval.load      = !i_off && (w_next != i_raw);
        o_eval.raw       = w_next;
        o_eval.pending   = (w_next != i_settled);
        o_eval.countdown = (w_next != i_settled) ? w_delay : 4'd0;
    end

endmodule

### hdl/comparator_peripheral_hysteresis.sv
// ----------------------------------------------------------------------------
// comparator_peripheral_hysteresis
// Bus-mapped analog comparator with hysteresis, settling delay and edge flag.
// ----------------------------------------------------------------------------
// The result word of an accepted input word is registered for output.
// Throughput: one word per cycle while o_in_ready is high; all state updates in the accepting cycle.
// An output register plus one skid entry take one more word while a result
// waits; input stalls only when both hold a word. Reset (synchronous, active
// low) clears all state; status address goes to 80, hysteresis band to zero.
module comparator_peripheral_hysteresis #(
    parameter int LEVEL_BITS = cph_pkg::LEVEL_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  cph_pkg::t_in                        i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output cph_pkg::t_out                       o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cph_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cph_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import cph_pkg::*;

    localparam int LW_MIN = (LEVEL_BITS < 16) ? LEVEL_BITS : 16;

    // Configuration
    logic [15:0] r_status_addr;
    logic [15:0] r_band;

    // Comparator state
    logic [7:0]            r_status,  n_status;
    logic [LEVEL_BITS-1:0] r_pos,     n_pos;
    logic [LEVEL_BITS-1:0] r_neg,     n_neg;
    logic                  r_raw,     n_raw;
    logic                  r_settled, n_settled;
    logic                  r_pending, n_pending;
    logic [3:0]            r_cnt,     n_cnt;

    // Output staging
    logic  r_out_valid;
    t_out  r_out;
    logic  r_skid_valid;
    t_out  r_skid;

    logic                  w_accept;
    logic                  w_take;
    logic                  w_match;
    logic [LEVEL_BITS-1:0] w_lvl;
    logic [7:0]            w_status_wr;
    logic                  w_do_eval;
    logic [LEVEL_BITS-1:0] w_eval_pos;
    logic [LEVEL_BITS-1:0] w_eval_neg;
    t_eval                 w_eval;
    logic                  w_trig;
    t_out                  w_res;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_skid_valid;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_take      = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_match = (i_in.bus_address == r_status_addr);

    always_comb begin
        w_lvl = '0;
        w_lvl[LW_MIN-1:0] = i_in.level[LW_MIN-1:0];
    end

    // Status after a matching bus write; output and flag bits are kept,
    // writing one to the flag clears it
    always_comb begin
        w_status_wr = r_status;
        if (i_in.action == ACT_WRITE && w_match) begin
            w_status_wr = i_in.write_data;
            w_status_wr[BIT_OUTPUT] = r_status[BIT_OUTPUT];
            w_status_wr[BIT_FLAG]   = r_status[BIT_FLAG] && !i_in.write_data[BIT_FLAG];
        end
    end

    assign w_eval_pos = (i_in.action == ACT_SET_POS) ? w_lvl : r_pos;
    assign w_eval_neg = (i_in.action == ACT_SET_NEG) ? w_lvl : r_neg;
    assign w_do_eval  = (i_in.action == ACT_SET_POS) || (i_in.action == ACT_SET_NEG)
                     || (i_in.action == ACT_WRITE && w_match);

    cph_eval #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_eval (
        .i_pos     (w_eval_pos),
        .i_neg     (w_eval_neg),
        .i_band    (r_band),
        .i_raw     (r_raw),
        .i_settled (r_settled),
        .i_off     (w_status_wr[BIT_DISABLE]),
        .o_eval    (w_eval)
    );

    always_comb begin
        case (r_status[1:0])
            MODE_TOGGLE:  w_trig = 1'b1;
            MODE_NONE:    w_trig = 1'b0;
            MODE_FALLING: w_trig = !r_raw;
            MODE_RISING:  w_trig = r_raw;
            default:      w_trig = 1'b0;
        endcase
    end

    always_comb begin
        n_status  = w_status_wr;
        n_pos     = r_pos;
        n_neg     = r_neg;
        n_raw     = r_raw;
        n_settled = r_settled;
        n_pending = r_pending;
        n_cnt     = r_cnt;
        w_res     = '0;

        case (i_in.action)
            ACT_READ: begin
                if (w_match) begin
                    w_res.read_data = r_status;
                    w_res.read_data[BIT_OUTPUT] = r_settled && !r_status[BIT_DISABLE];
                end
            end
            ACT_SET_POS: begin
                n_pos = w_lvl;
            end
            ACT_SET_NEG: begin
                n_neg = w_lvl;
            end
            ACT_TICK: begin
                if (r_cnt != 4'd0) begin
                    n_cnt = r_cnt - 4'd1;
                    // Expire: drop it while disabled
                    if (r_cnt == 4'd1 && !r_status[BIT_DISABLE] && r_pending) begin
                        n_settled = r_raw;
                        n_pending = 1'b0;
                        if (r_raw != r_settled && w_trig) begin
                            n_status[BIT_FLAG] = 1'b1;
                        end
                    end
                end
            end
            ACT_IRQ_ACK: begin
                if (r_status[BIT_FLAG] && r_status[BIT_IE]) begin
                    n_status[BIT_FLAG] = 1'b0;
                    w_res.ack_taken = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (w_do_eval && w_eval.load) begin
            n_raw     = w_eval.raw;
            n_pending = w_eval.pending;
            n_cnt     = w_eval.countdown;
        end

        w_res.comparator_out = n_settled;
        w_res.irq_request    = n_status[BIT_FLAG] && n_status[BIT_IE];
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status_addr <= 16'd80;
            r_band        <= 16'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_STATUS_ADDR) begin
                r_status_addr <= i_cfg_data;
            end else if (i_cfg_index == CFG_HYST_BAND) begin
                r_band <= i_cfg_data;
            end
        end
    end

    // Comparator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status  <= '0;
            r_pos     <= '0;
            r_neg     <= '0;
            r_raw     <= 1'b0;
            r_settled <= 1'b0;
            r_pending <= 1'b0;
            r_cnt     <= '0;
        end else if (w_accept) begin
            r_status  <= n_status;
            r_pos     <= n_pos;
            r_neg     <= n_neg;
            r_raw     <= n_raw;
            r_settled <= n_settled;
            r_pending <= n_pending;
            r_cnt     <= n_cnt;
        end
    end

    // Output register and skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || w_take) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= w_accept;
                end
            end else if (w_accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_accept) begin
                r_out <= w_res;
            end
        end else if (w_accept) begin
            r_skid <= w_res;
        end
    end

    // A parked word always sits behind a held one
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // A running countdown always belongs to a pending update
    a_cnt_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 4'd0) |-> r_pending)
        else $error("settle countdown running without pending update");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DLY_CRAWL)
        else $error("settle countdown beyond longest delay");

    // The settled output moves only on an accepted tick
    a_settle_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_settled != $past(r_settled)) |-> $past(w_accept && i_in.action == ACT_TICK))
        else $error("settled output changed outside a tick");

    a_output_not_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_status[BIT_OUTPUT])
        else $error("output bit stored in status register");

    // An acknowledge leaves no request standing
    a_ack_clears_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.ack_taken) |-> !o_out.irq_request)
        else $error("interrupt request still set after acknowledge");

endmodule
